FILE: design/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, including while reset is low
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

// property checked only while reset (active low) is released
`define ASSERT_RUN(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

`endif

FILE: design/ipk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipk_pkg
// Types and constants of the iambic paddle keyer.
// ----------------------------------------------------------------------------
package ipk_pkg;

    localparam int DIT_W  = 11;
    localparam int MARK_W = 12;
    localparam int ELEM_W = 2;

    localparam logic [DIT_W-1:0]  DIT_MAX    = 11'd1200;
    localparam logic [DIT_W-1:0]  DIT_MIN    = 11'd1;
    localparam logic [DIT_W-1:0]  DIT_RESET  = 11'd60;
    localparam logic [MARK_W-1:0] DAH_FACTOR = 12'd3;

    // register index of dit_ticks
    localparam logic REG_DIT_TICKS = 1'b0;

    localparam logic [ELEM_W-1:0] ELEM_IDLE = 2'd0;
    localparam logic [ELEM_W-1:0] ELEM_DIT  = 2'd1;
    localparam logic [ELEM_W-1:0] ELEM_DAH  = 2'd2;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_DIT  = 3'b010,
        MODE_DAH  = 3'b100
    } mode_t;

    typedef struct packed {
        logic dit_paddle;
        logic dah_paddle;
    } in_t;

    typedef struct packed {
        logic              key_out;
        logic [ELEM_W-1:0] element;
    } out_t;

endpackage

FILE: design/ipk_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipk_core
// Keyer state and per-tick next-state logic; one tick is taken per step.
// ----------------------------------------------------------------------------
module ipk_core #(
    parameter int TIMER_WIDTH = 12
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step_en,
    input  ipk_pkg::in_t                step_in,
    input  logic [ipk_pkg::DIT_W-1:0]   dit_ticks,
    output ipk_pkg::out_t               step_out
);

    localparam int CW = ((TIMER_WIDTH > ipk_pkg::MARK_W) ? TIMER_WIDTH
                                                         : ipk_pkg::MARK_W) + 1;
    localparam logic [CW-1:0] TIMER_MAX = CW'((1 << TIMER_WIDTH) - 1);

    ipk_pkg::mode_t           mode_reg, mode_next;
    logic                     in_space_reg, in_space_next;
    logic [TIMER_WIDTH-1:0]   tick_reg, tick_next;
    logic                     dit_mem_reg, dit_mem_next;
    logic                     dah_mem_reg, dah_mem_next;

    ipk_pkg::mode_t           mode_w;
    logic                     in_space_w;
    logic [TIMER_WIDTH-1:0]   tick_w;
    logic                     dit_mem_w;
    logic                     dah_mem_w;
    logic [ipk_pkg::DIT_W-1:0]  dit_len;
    logic [ipk_pkg::MARK_W-1:0] dah_len;
    logic [CW-1:0]            len_raw;
    logic [CW-1:0]            len;
    logic [CW-1:0]            tick_inc;
    logic                     done;

    always_comb begin
        if (dit_ticks == '0) begin
            dit_len = ipk_pkg::DIT_MIN;
        end else if (dit_ticks > ipk_pkg::DIT_MAX) begin
            dit_len = ipk_pkg::DIT_MAX;
        end else begin
            dit_len = dit_ticks;
        end
        dah_len = ipk_pkg::MARK_W'(dit_len) * ipk_pkg::DAH_FACTOR;
    end

    always_comb begin
        mode_w     = mode_reg;
        in_space_w = in_space_reg;
        tick_w     = tick_reg;
        dit_mem_w  = dit_mem_reg;
        dah_mem_w  = dah_mem_reg;

        // idle choice, or opposite-paddle latch of the running element
        case (mode_reg)
            ipk_pkg::MODE_DIT: begin
                if (step_in.dah_paddle) dah_mem_w = 1'b1;
            end
            ipk_pkg::MODE_DAH: begin
                if (step_in.dit_paddle) dit_mem_w = 1'b1;
            end
            default: begin
                mode_w = ipk_pkg::MODE_IDLE;
                if (step_in.dah_paddle) begin
                    mode_w     = ipk_pkg::MODE_DAH;
                    in_space_w = 1'b0;
                    tick_w     = '0;
                    dit_mem_w  = step_in.dit_paddle;
                end else if (step_in.dit_paddle) begin
                    mode_w     = ipk_pkg::MODE_DIT;
                    in_space_w = 1'b0;
                    tick_w     = '0;
                    dah_mem_w  = 1'b0;
                end
            end
        endcase
    end

    always_comb begin
        if (!in_space_w && mode_w == ipk_pkg::MODE_DAH) begin
            len_raw = CW'(dah_len);
        end else begin
            len_raw = CW'(dit_len);
        end
        len      = (len_raw > TIMER_MAX) ? TIMER_MAX : len_raw;
        tick_inc = CW'(tick_w) + CW'(1);
        done     = (tick_inc >= len);
    end

    always_comb begin
        step_out.key_out = 1'b0;
        step_out.element = ipk_pkg::ELEM_IDLE;
        mode_next        = mode_w;
        in_space_next    = in_space_w;
        tick_next        = tick_w;
        dit_mem_next     = dit_mem_w;
        dah_mem_next     = dah_mem_w;

        case (mode_w)
            ipk_pkg::MODE_DIT, ipk_pkg::MODE_DAH: begin
                step_out.key_out = !in_space_w;
                step_out.element = (mode_w == ipk_pkg::MODE_DAH) ? ipk_pkg::ELEM_DAH
                                                                 : ipk_pkg::ELEM_DIT;
                if (done) begin
                    tick_next = '0;
                    if (!in_space_w) begin
                        in_space_next = 1'b1;
                    end else if (mode_w == ipk_pkg::MODE_DIT && dah_mem_w) begin
                        mode_next     = ipk_pkg::MODE_DAH;
                        in_space_next = 1'b0;
                        dit_mem_next  = 1'b0;
                    end else if (mode_w == ipk_pkg::MODE_DAH && dit_mem_w) begin
                        mode_next     = ipk_pkg::MODE_DIT;
                        in_space_next = 1'b0;
                        dah_mem_next  = 1'b0;
                    end else begin
                        mode_next     = ipk_pkg::MODE_IDLE;
                        in_space_next = 1'b0;
                    end
                end else begin
                    tick_next = tick_inc[TIMER_WIDTH-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= ipk_pkg::MODE_IDLE;
            in_space_reg <= 1'b0;
            tick_reg     <= '0;
            dit_mem_reg  <= 1'b0;
            dah_mem_reg  <= 1'b0;
        end else if (step_en) begin
            mode_reg     <= mode_next;
            in_space_reg <= in_space_next;
            tick_reg     <= tick_next;
            dit_mem_reg  <= dit_mem_next;
            dah_mem_reg  <= dah_mem_next;
        end
    end

endmodule

FILE: design/iambic_paddle_keyer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iambic_paddle_keyer_unit
// Iambic paddle keyer with dit/dah element memory, one request per ms tick.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one request per millisecond tick with both paddle levels.
//   m_ channel: exactly one result per request, key_out and current element,
//   in request order.
//   APB port: register 0 at byte address 0 holds dit_ticks (1200 / wpm);
//   write it only while the keyer is idle and all results are drained.
// Output: results are registered, in the skid entry while the output stalls.
// Throughput: one request per cycle while s_ready is high; the keyer state
//   updates in the same cycle a request is taken, one next-state pass per tick.
// Stall: a two-entry output buffer holds results; with both entries full
//   s_ready drops until the receiver takes one, and nothing is lost.
// Reset: aresetn clears the keyer to idle with no latched element, empties
//   the output buffer and sets dit_ticks to 60.
// ----------------------------------------------------------------------------
module iambic_paddle_keyer_unit #(
    parameter int TIMER_WIDTH = 12
) (
    input  logic          aclk,
    input  logic          aresetn,

    input  logic          s_valid,
    output logic          s_ready,
    input  ipk_pkg::in_t  s_data,

    output logic          m_valid,
    input  logic          m_ready,
    output ipk_pkg::out_t m_data,

    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [ipk_pkg::DIT_W-1:0] dit_ticks_reg;
    logic                      s_take;
    logic                      m_take;
    ipk_pkg::out_t             step_out;

    logic                      out_valid_reg;
    ipk_pkg::out_t             out_data_reg;
    logic                      skid_valid_reg;
    ipk_pkg::out_t             skid_data_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dit_ticks_reg <= ipk_pkg::DIT_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == ipk_pkg::REG_DIT_TICKS) begin
            dit_ticks_reg <= pwdata[ipk_pkg::DIT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == ipk_pkg::REG_DIT_TICKS) begin
            prdata = 32'(dit_ticks_reg);
        end
    end

    assign s_ready = !skid_valid_reg;
    assign s_take  = s_valid && s_ready;
    assign m_take  = out_valid_reg && m_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    ipk_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_ipk_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (s_take),
        .step_in   (s_data),
        .dit_ticks (dit_ticks_reg),
        .step_out  (step_out)
    );

    // output register plus skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_take || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= s_take;
            end
        end else if (s_take) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_take || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (s_take) begin
                out_data_reg <= step_out;
            end
        end else if (s_take) begin
            skid_data_reg <= step_out;
        end
    end

endmodule

FILE: design/ipk_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipk_checker
// Port-level checks of the keyer unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipk_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input ipk_pkg::out_t m_data
);

    logic stalled;
    logic elem_busy;
    logic elem_legal;

    assign stalled    = m_valid && !m_ready;
    assign elem_busy  = (m_data.element != ipk_pkg::ELEM_IDLE);
    assign elem_legal = (m_data.element == ipk_pkg::ELEM_IDLE)
                     || (m_data.element == ipk_pkg::ELEM_DIT)
                     || (m_data.element == ipk_pkg::ELEM_DAH);

    // reset empties the result buffer
    `ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid)

    // a stalled result holds
    `ASSERT_RUN(a_stall_holds, aclk, aresetn, stalled |=> m_valid && $stable(m_data))

    // back-pressure only with results waiting
    `ASSERT_RUN(a_ready_low_full, aclk, aresetn, !s_ready |-> m_valid)

    // keying only happens inside an element
    `ASSERT_RUN(a_key_in_element, aclk, aresetn, m_valid && m_data.key_out |-> elem_busy)

    `ASSERT_RUN(a_element_code, aclk, aresetn, m_valid |-> elem_legal)

endmodule

bind iambic_paddle_keyer_unit ipk_checker u_ipk_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the iambic paddle keyer. Paddle ticks are fed from
// a queue through a valid/ready driver while a clocked monitor runs a keyer
// model on every taken request and compares each result field by field.
// Several dit lengths are programmed over APB: zero, one, small values and an
// over-range value, the reset value first. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;

    localparam int TIMER_WIDTH  = 12;
    localparam int TIMER_MAX    = (1 << TIMER_WIDTH) - 1;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int TAIL_CYCLES  = 20;

    localparam logic [2:0] DIT_TICKS_ADDR = {ipk_pkg::REG_DIT_TICKS, 2'b00};
    localparam logic [2:0] UNUSED_ADDR    = 3'd4;

    // {dit, dah} per tick, first tick in the top bits
    localparam int          N_DIRECTED   = 22;
    localparam logic [43:0] DIRECTED_SEQ =
        44'b00_00_11_00_00_00_00_10_01_00_00_00_01_10_10_00_00_00_00_10_00_11;

    logic          aclk    = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    ipk_pkg::in_t  s_data  = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    ipk_pkg::out_t m_data;
    logic          psel    = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite  = 1'b0;
    logic [2:0]    paddr   = '0;
    logic [31:0]   pwdata  = '0;
    logic [31:0]   prdata;
    logic          pready;

    ipk_pkg::in_t  tick_q[$];
    ipk_pkg::out_t key_expect_q[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int errors         = 0;
    int ticks_checked  = 0;
    int keyed_ticks    = 0;
    int dit_settings   = 1;
    int cycles         = 0;

    // keyer model state
    logic [ipk_pkg::DIT_W-1:0] dit_cfg;
    ipk_pkg::mode_t            ky_mode;
    logic                      ky_space;
    logic [TIMER_WIDTH-1:0]    ky_count;
    logic                      mem_dit;
    logic                      mem_dah;

    iambic_paddle_keyer_unit #(
        .TIMER_WIDTH(TIMER_WIDTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #5 aclk = ~aclk;

    function automatic int unsigned eff_dit();
        if (dit_cfg == '0) return 1;
        if (dit_cfg > ipk_pkg::DIT_MAX) return 32'(ipk_pkg::DIT_MAX);
        return 32'(dit_cfg);
    endfunction

    function automatic void begin_element(ipk_pkg::mode_t which);
        ky_mode  = which;
        ky_space = 1'b0;
        ky_count = '0;
        if (which == ipk_pkg::MODE_DIT) begin
            mem_dah = 1'b0;
        end else begin
            mem_dit = 1'b0;
        end
    endfunction

    function automatic ipk_pkg::out_t keyer_tick(ipk_pkg::in_t paddles);
        int unsigned   d;
        int unsigned   len;
        ipk_pkg::out_t res;
        d   = eff_dit();
        res = '{key_out: 1'b0, element: ipk_pkg::ELEM_IDLE};
        if (ky_mode != ipk_pkg::MODE_DIT && ky_mode != ipk_pkg::MODE_DAH) begin
            ky_mode = ipk_pkg::MODE_IDLE;
            // dah wins when both paddles are down
            if (paddles.dah_paddle) begin
                begin_element(ipk_pkg::MODE_DAH);
            end else if (paddles.dit_paddle) begin
                begin_element(ipk_pkg::MODE_DIT);
            end
        end
        if (ky_mode != ipk_pkg::MODE_IDLE) begin
            if (ky_mode == ipk_pkg::MODE_DIT) begin
                if (paddles.dah_paddle) mem_dah = 1'b1;
            end else begin
                if (paddles.dit_paddle) mem_dit = 1'b1;
            end
            res.key_out = !ky_space;
            res.element = (ky_mode == ipk_pkg::MODE_DAH) ? ipk_pkg::ELEM_DAH
                                                          : ipk_pkg::ELEM_DIT;
            if (!ky_space && ky_mode == ipk_pkg::MODE_DAH) begin
                len = d * 32'(ipk_pkg::DAH_FACTOR);
            end else begin
                len = d;
            end
            if (len > TIMER_MAX) len = TIMER_MAX;
            if (32'(ky_count) + 1 >= len) begin
                ky_count = '0;
                if (!ky_space) begin
                    ky_space = 1'b1;
                end else if (ky_mode == ipk_pkg::MODE_DIT && mem_dah) begin
                    begin_element(ipk_pkg::MODE_DAH);
                end else if (ky_mode == ipk_pkg::MODE_DAH && mem_dit) begin
                    begin_element(ipk_pkg::MODE_DIT);
                end else begin
                    ky_mode  = ipk_pkg::MODE_IDLE;
                    ky_space = 1'b0;
                end
            end else begin
                ky_count = ky_count + 1'b1;
            end
        end
        return res;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || s_ready) begin
                if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= tick_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        ipk_pkg::out_t want;
        if (!aresetn) begin
            dit_cfg  = ipk_pkg::DIT_RESET;
            ky_mode  = ipk_pkg::MODE_IDLE;
            ky_space = 1'b0;
            ky_count = '0;
            mem_dit  = 1'b0;
            mem_dah  = 1'b0;
            key_expect_q.delete();
        end else begin
            if (psel && penable && pwrite && pready
                && paddr[2] == ipk_pkg::REG_DIT_TICKS) begin
                dit_cfg = pwdata[ipk_pkg::DIT_W-1:0];
            end
            if (s_valid && s_ready) begin
                key_expect_q.push_back(keyer_tick(s_data));
            end
            if (m_valid && m_ready) begin
                if (key_expect_q.size() == 0) begin
                    $display("%0t: unexpected result key_out %0b element %0d",
                             $realtime, m_data.key_out, m_data.element);
                    errors++;
                end else begin
                    want = key_expect_q.pop_front();
                    ticks_checked++;
                    if (want.key_out) keyed_ticks++;
                    if (m_data.key_out !== want.key_out) begin
                        $display("%0t: key_out expected %0b actual %0b",
                                 $realtime, want.key_out, m_data.key_out);
                        errors++;
                    end
                    if (m_data.element !== want.element) begin
                        $display("%0t: element expected %0d actual %0d",
                                 $realtime, want.element, m_data.element);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, key_expect_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic wait_drained();
        while (tick_q.size() != 0 || s_valid || key_expect_q.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // let the keyer finish its elements so a register write lands while idle
    task automatic settle_idle();
        wait_drained();
        while (ky_mode != ipk_pkg::MODE_IDLE) begin
            repeat (16) tick_q.push_back('0);
            wait_drained();
        end
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        if (addr == DIT_TICKS_ADDR) dit_settings++;
    endtask

    // paddle gestures: holds, squeezes, releases and noise, sized to the dit
    task automatic add_gestures(input int n_ticks);
        int           made;
        int           run;
        int           kind;
        ipk_pkg::in_t paddles;
        made = 0;
        while (made < n_ticks) begin
            kind = $urandom_range(9);
            run  = $urandom_range(4 * eff_dit() + 2, 1);
            while (run > 0 && made < n_ticks) begin
                case (kind)
                    0, 1, 2: paddles = '{dit_paddle: 1'b1, dah_paddle: 1'b0};
                    3, 4, 5: paddles = '{dit_paddle: 1'b0, dah_paddle: 1'b1};
                    6, 7:    paddles = '{dit_paddle: 1'b1, dah_paddle: 1'b1};
                    8:       paddles = '0;
                    default: paddles = ipk_pkg::in_t'(2'($urandom_range(3)));
                endcase
                tick_q.push_back(paddles);
                run--;
                made++;
                // hold the sender back until everything is answered
                if (made % 300 == 0) wait_drained();
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct  = 15;
        recv_stall_pct = 87;
        add_gestures(200);
        settle_idle();

        write_reg(DIT_TICKS_ADDR, 32'd1);
        for (int i = 0; i < N_DIRECTED; i++) begin
            tick_q.push_back(ipk_pkg::in_t'(DIRECTED_SEQ[43 - 2 * i -: 2]));
        end
        add_gestures(200);
        settle_idle();

        send_idle_pct  = 87;
        recv_stall_pct = 15;
        // zero acts as one; the unused address must not touch dit_ticks
        write_reg(DIT_TICKS_ADDR, 32'd0);
        write_reg(UNUSED_ADDR, 32'h0000_0005);
        add_gestures(250);
        settle_idle();

        write_reg(DIT_TICKS_ADDR, 32'd2);
        add_gestures(250);
        settle_idle();

        write_reg(DIT_TICKS_ADDR, 32'd5);
        add_gestures(250);
        settle_idle();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // all ones, clamps to the longest dit
        write_reg(DIT_TICKS_ADDR, 32'h0000_07FF);
        add_gestures(100);
        settle_idle();

        write_reg(DIT_TICKS_ADDR, 32'd3);
        add_gestures(300);
        settle_idle();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("checked %0d keyer ticks (%0d keyed) over %0d dit lengths",
                 ticks_checked, keyed_ticks, dit_settings);
        $display("dit lengths 0, 1, 2, 3, 5, 60 and over-range, with stalls on both sides");
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches", errors);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
